// ===== rtl/rcida_pkg.sv =====
// Shared command, status and control types for the refcounted id allocator.
`default_nettype none
package rcida_pkg;

   // Command codes
   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_ADDREF  = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;

   // Status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_NOFREE = 2'd1;
   localparam logic [1:0] STATUS_BADID  = 2'd2;
   localparam logic [1:0] STATUS_SAT    = 2'd3;

   localparam int ID_PORT_BITS    = 10;
   localparam int COUNT_PORT_BITS = 16;

   typedef enum logic [1:0] {
      ST_ACCEPT = 2'b01,
      ST_EXEC   = 2'b10
   } state_type;

   // Decisions of the execute step, passed to the sequencer
   typedef struct packed {
      logic       count_we;
      logic       pop;
      logic       issue;
      logic       push;
      logic [1:0] status;
      logic       freed;
   } exec_ctl_type;

endpackage
`default_nettype wire

// ===== rtl/rcida_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module rcida_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/rcida_exec.sv =====
// Execute step: decides the memory updates and the result of one command.
`default_nettype none
module rcida_exec #(
   parameter int MAX_IDS    = 1024,
   parameter int COUNT_BITS = 16
) (
   input  wire logic [1:0]                       cmd,
   input  wire logic [rcida_pkg::ID_PORT_BITS-1:0] target_id,
   input  wire logic [COUNT_BITS-1:0]            count_rdata,
   input  wire logic [$clog2(MAX_IDS)-1:0]       stack_rdata,
   input  wire logic [$clog2(MAX_IDS):0]         issued_count,
   input  wire logic [$clog2(MAX_IDS):0]         free_top,
   output rcida_pkg::exec_ctl_type               ctl,
   output logic      [$clog2(MAX_IDS)-1:0]       count_wr_addr,
   output logic      [COUNT_BITS-1:0]            count_wr_data,
   output logic      [rcida_pkg::ID_PORT_BITS-1:0] result_id,
   output logic      [rcida_pkg::COUNT_PORT_BITS-1:0] ref_count
);
   import rcida_pkg::*;

   localparam int IW   = $clog2(MAX_IDS);
   localparam int CNTW = IW + 1;
   localparam int CMPW = ((IW > ID_PORT_BITS) ? IW : ID_PORT_BITS) + 1;
   localparam int RW   = (COUNT_BITS > COUNT_PORT_BITS) ? COUNT_BITS : COUNT_PORT_BITS;

   logic [CMPW-1:0]       tid_wide;
   logic [CMPW-1:0]       issued_wide;
   logic [CMPW-1:0]       alloc_wide;
   logic [IW-1:0]         alloc_id;
   logic [COUNT_BITS-1:0] count_inc;
   logic [COUNT_BITS-1:0] count_dec;
   logic [COUNT_BITS-1:0] count_rep;
   logic [RW-1:0]         count_wide;
   logic                  bad_id;

   assign tid_wide    = CMPW'(target_id);
   assign issued_wide = CMPW'(issued_count);
   assign count_inc   = count_rdata + COUNT_BITS'(1);
   assign count_dec   = count_rdata - COUNT_BITS'(1);
   assign alloc_wide  = CMPW'(alloc_id);
   assign count_wide  = RW'(count_rep);
   assign ref_count   = count_wide[COUNT_PORT_BITS-1:0];

   // cmd 3 falls in with the bad-identifier case
   assign bad_id = !(cmd == CMD_ADDREF || cmd == CMD_RELEASE) ||
                   (tid_wide >= issued_wide) || (count_rdata == '0);

   always_comb begin
      ctl           = '0;
      ctl.status    = STATUS_OK;
      alloc_id      = stack_rdata;
      count_wr_addr = tid_wide[IW-1:0];
      count_wr_data = count_inc;
      count_rep     = '0;
      result_id     = target_id;
      if (cmd == CMD_ALLOC) begin
         if (free_top != '0) begin
            ctl.pop = 1'b1;
         end else begin
            alloc_id  = issued_count[IW-1:0];
            ctl.issue = (issued_count != CNTW'(MAX_IDS));
         end
         if (ctl.pop || ctl.issue) begin
            ctl.count_we  = 1'b1;
            count_wr_addr = alloc_id;
            count_wr_data = COUNT_BITS'(1);
            count_rep     = COUNT_BITS'(1);
            result_id     = alloc_wide[ID_PORT_BITS-1:0];
         end else begin
            ctl.status = STATUS_NOFREE;
            result_id  = '0;
         end
      end else if (bad_id) begin
         ctl.status = STATUS_BADID;
      end else if (cmd == CMD_ADDREF) begin
         if (count_rdata == '1) begin
            ctl.status = STATUS_SAT;
            count_rep  = count_rdata;
         end else begin
            ctl.count_we = 1'b1;
            count_rep    = count_inc;
         end
      end else begin
         ctl.count_we  = 1'b1;
         count_wr_data = count_dec;
         count_rep     = count_dec;
         if (count_dec == '0 && free_top != CNTW'(MAX_IDS)) begin
            ctl.push  = 1'b1;
            ctl.freed = 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/refcounted_id_allocator_top.sv =====
// Top level of the refcounted id allocator: handshake, sequencer, state memories.
// An accepted command reads the count and free stack memories, executes, and registers
// its result onto rsp_*; execution waits while an earlier result is unaccepted. A new
// command is taken only after the previous one is written back through the write ports.
// Reset clears the issued counter, the free stack depth and the output valid;
// the count and free stack memories are not cleared and need no clearing pass.
`default_nettype none
module refcounted_id_allocator_top #(
   parameter int MAX_IDS    = 1024,
   parameter int COUNT_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // [9:0] target_id
   input  wire logic [1:0]  req_tuser,  // [1:0] cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,  // [9:0] result_id, [25:10] ref_count
   output logic      [2:0]  rsp_tuser   // [1:0] status, [2] freed
);
   import rcida_pkg::*;

   localparam int IW   = $clog2(MAX_IDS);
   localparam int CNTW = IW + 1;
   localparam int CMPW = ((IW > ID_PORT_BITS) ? IW : ID_PORT_BITS) + 1;

   state_type state_ff, state_in;
   logic [CNTW-1:0] issued_ff, issued_in;
   logic [CNTW-1:0] free_top_ff, free_top_in;
   logic [CNTW-1:0] free_top_m1;
   logic [1:0]      cmd_ff;
   logic [ID_PORT_BITS-1:0] tid_ff;
   logic [CMPW-1:0] req_tid_wide;
   logic [CMPW-1:0] tid_ff_wide;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ID_PORT_BITS-1:0]   rsp_id_ff;
   logic [COUNT_PORT_BITS-1:0] rsp_count_ff;
   logic [1:0]                rsp_status_ff;
   logic                      rsp_freed_ff;

   logic                   accept;
   logic                   exec_go;
   exec_ctl_type           ctl;
   logic [IW-1:0]          count_wr_addr;
   logic [COUNT_BITS-1:0]  count_wr_data;
   logic [COUNT_BITS-1:0]  count_rdata;
   logic [IW-1:0]          stack_rdata;
   logic [ID_PORT_BITS-1:0] ex_result_id;
   logic [COUNT_PORT_BITS-1:0] ex_ref_count;

   assign req_tready   = (state_ff == ST_ACCEPT);
   assign accept       = req_tvalid && req_tready;
   assign exec_go      = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign req_tid_wide = CMPW'(req_tdata[ID_PORT_BITS-1:0]);
   assign tid_ff_wide  = CMPW'(tid_ff);
   assign free_top_m1  = free_top_ff - CNTW'(1);

   rcida_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_IDS)) u_count_ram (
      .clock   (clock),
      .wr_en   (exec_go && ctl.count_we),
      .wr_addr (count_wr_addr),
      .wr_data (count_wr_data),
      .rd_en   (accept),
      .rd_addr (req_tid_wide[IW-1:0]),
      .rd_data (count_rdata)
   );

   // Top of stack is read with every command; only allocate uses it
   rcida_ram #(.WIDTH(IW), .DEPTH(MAX_IDS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (exec_go && ctl.push),
      .wr_addr (free_top_ff[IW-1:0]),
      .wr_data (tid_ff_wide[IW-1:0]),
      .rd_en   (accept),
      .rd_addr (free_top_m1[IW-1:0]),
      .rd_data (stack_rdata)
   );

   rcida_exec #(.MAX_IDS(MAX_IDS), .COUNT_BITS(COUNT_BITS)) u_exec (
      .cmd           (cmd_ff),
      .target_id     (tid_ff),
      .count_rdata   (count_rdata),
      .stack_rdata   (stack_rdata),
      .issued_count  (issued_ff),
      .free_top      (free_top_ff),
      .ctl           (ctl),
      .count_wr_addr (count_wr_addr),
      .count_wr_data (count_wr_data),
      .result_id     (ex_result_id),
      .ref_count     (ex_ref_count)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_ACCEPT: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_ACCEPT;
            end
         end
         default: state_in = ST_ACCEPT;
      endcase
   end

   always_comb begin
      issued_in   = issued_ff;
      free_top_in = free_top_ff;
      if (exec_go) begin
         if (ctl.issue) begin
            issued_in = issued_ff + CNTW'(1);
         end
         if (ctl.pop) begin
            free_top_in = free_top_m1;
         end else if (ctl.push) begin
            free_top_in = free_top_ff + CNTW'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCEPT;
         issued_ff    <= '0;
         free_top_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         free_top_ff  <= free_top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_tuser;
         tid_ff <= req_tdata[ID_PORT_BITS-1:0];
      end
      if (exec_go) begin
         rsp_id_ff     <= ex_result_id;
         rsp_count_ff  <= ex_ref_count;
         rsp_status_ff <= ctl.status;
         rsp_freed_ff  <= ctl.freed;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_count_ff, rsp_id_ff};
   assign rsp_tuser  = {rsp_freed_ff, rsp_status_ff};

   // Every freed id was issued earlier
   assert property (@(posedge clock) disable iff (reset) free_top_ff <= issued_ff)
      else $error("free stack deeper than issued ids");

   assert property (@(posedge clock) disable iff (reset) issued_ff <= CNTW'(MAX_IDS))
      else $error("issued counter beyond id space");

   assert property (@(posedge clock) disable iff (reset) accept |=> !req_tready)
      else $error("input taken while a command is in execution");

   assert property (@(posedge clock) disable iff (reset)
      (free_top_ff != $past(free_top_ff)) |-> ($past(state_ff) == ST_EXEC))
      else $error("free stack moved outside execution");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_freed_ff) |-> (rsp_status_ff == STATUS_OK && rsp_count_ff == '0))
      else $error("freed result with nonzero count or bad status");

endmodule
`default_nettype wire

// ===== tb/refcounted_id_allocator_top_test.sv =====
// Self-checking testbench for the refcounted id allocator: directed, backpressure, random.
`default_nettype none
module refcounted_id_allocator_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rcida_pkg::*;

   localparam int MAX_IDS      = 1024;
   localparam int COUNT_BITS   = 16;
   localparam int LIMIT_CYCLES = 2_000_000;
   localparam int RANDOM_ITEMS = 500;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [ID_PORT_BITS-1:0]    result_id;
      logic [1:0]                 status;
      logic [COUNT_PORT_BITS-1:0] ref_count;
      logic                       freed;
   } alloc_rsp_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [9:0] target_id
   logic [1:0]  req_tuser;   // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [9:0] result_id, [25:10] ref_count
   logic [2:0]  rsp_tuser;   // [1:0] status, [2] freed

   // shadow copy of the allocator state
   int                    issued_cnt;
   int                    stack_depth;
   logic [COUNT_BITS-1:0] id_refs [MAX_IDS];
   logic [9:0]            free_ids [MAX_IDS];

   alloc_rsp_type pending_rsps [$];

   int errors;
   int cycles;
   int n_cmds, n_freed, n_sat, n_nofree, n_badid;
   bit gaps_on;
   bit rx_random;
   int hold_len;

   refcounted_id_allocator_top #(
      .MAX_IDS   (MAX_IDS),
      .COUNT_BITS(COUNT_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("refcounted_id_allocator_top: mismatch");
         $finish;
      end
   end

   // Applies one command to the shadow state and returns the expected result.
   function automatic alloc_rsp_type apply_command(input logic [1:0] cmd, input logic [9:0] tid);
      alloc_rsp_type r;
      int id;
      logic [COUNT_BITS-1:0] cnt;
      r = '0;
      n_cmds++;
      if (cmd == CMD_ALLOC) begin
         if (stack_depth > 0) begin
            stack_depth--;
            id = free_ids[stack_depth];
         end else if (issued_cnt < MAX_IDS) begin
            id = issued_cnt;
            issued_cnt++;
         end else begin
            n_nofree++;
            r.status = STATUS_NOFREE;
            return r;
         end
         id_refs[id] = COUNT_BITS'(1);
         r.result_id = ID_PORT_BITS'(id);
         r.status    = STATUS_OK;
         r.ref_count = COUNT_PORT_BITS'(1);
         return r;
      end
      r.result_id = tid;
      if ((cmd != CMD_ADDREF && cmd != CMD_RELEASE) || tid >= issued_cnt || id_refs[tid] == 0)
      begin
         n_badid++;
         r.status = STATUS_BADID;
         return r;
      end
      cnt = id_refs[tid];
      if (cmd == CMD_ADDREF) begin
         if (cnt == COUNT_MAX) begin
            n_sat++;
            r.status    = STATUS_SAT;
            r.ref_count = cnt;
            return r;
         end
         cnt++;
         id_refs[tid] = cnt;
         r.status     = STATUS_OK;
         r.ref_count  = cnt;
         return r;
      end
      cnt--;
      id_refs[tid] = cnt;
      r.status     = STATUS_OK;
      r.ref_count  = cnt;
      if (cnt == 0 && stack_depth < MAX_IDS) begin
         free_ids[stack_depth] = tid;
         stack_depth++;
         r.freed = 1'b1;
         n_freed++;
      end
      return r;
   endfunction

   // Finds some identifier that is currently held, or a random one when none is.
   function automatic logic [9:0] pick_live();
      int start;
      int i;
      start = $urandom_range(0, MAX_IDS - 1);
      for (int k = 0; k < MAX_IDS; k++) begin
         i = (start + k) % MAX_IDS;
         if (i < issued_cnt && id_refs[i] != 0) return 10'(i);
      end
      return 10'(start);
   endfunction

   task automatic send_cmd(input logic [1:0] cmd, input logic [9:0] tid);
      int gap;
      int r;
      gap = 0;
      if (gaps_on) begin
         r = $urandom_range(0, 99);
         if (r >= 92) gap = $urandom_range(5, 30);
         else if (r >= 60) gap = $urandom_range(1, 3);
      end
      @(negedge clock);
      while (gap > 0) begin
         req_tvalid <= 1'b0;
         gap--;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, tid};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      pending_rsps = {pending_rsps, apply_command(cmd, tid)};
   endtask

   task automatic send_random_cmd();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) send_cmd(CMD_ALLOC, 10'($urandom));
      else if (r < 60) send_cmd(CMD_ADDREF, pick_live());
      else if (r < 88) send_cmd(CMD_RELEASE, pick_live());
      else if (r < 94) send_cmd($urandom_range(0, 1) ? CMD_ADDREF : CMD_RELEASE, 10'($urandom));
      else send_cmd(CMD_UNUSED, 10'($urandom));
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Receiver: always ready, random ready when rx_random is set, or a long hold when a test asks for one.
   initial begin
      int stall_left;
      int r;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_len > 0) begin
            rsp_tready <= 1'b0;
            hold_len--;
         end else if (!rx_random) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(5, 40);
            end
         end
      end
   end

   always @(posedge clock) begin
      alloc_rsp_type exp_rsp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsps.size() == 0) begin
            $error("unexpected result item: id %0d status %0d", rsp_tdata[9:0], rsp_tuser[1:0]);
            errors++;
         end else begin
            exp_rsp = pending_rsps.pop_front();
            if (rsp_tdata[9:0] !== exp_rsp.result_id) begin
               $error("result_id: expected %0d, got %0d", exp_rsp.result_id, rsp_tdata[9:0]);
               errors++;
            end
            if (rsp_tuser[1:0] !== exp_rsp.status) begin
               $error("status: expected %0d, got %0d", exp_rsp.status, rsp_tuser[1:0]);
               errors++;
            end
            if (rsp_tdata[25:10] !== exp_rsp.ref_count) begin
               $error("ref_count: expected %0d, got %0d", exp_rsp.ref_count, rsp_tdata[25:10]);
               errors++;
            end
            if (rsp_tuser[2] !== exp_rsp.freed) begin
               $error("freed: expected %0d, got %0d", exp_rsp.freed, rsp_tuser[2]);
               errors++;
            end
         end
      end
   end

   // Bad ids before anything is issued, LIFO reuse, zero-count release, unused command.
   task automatic test_directed();
      gaps_on   = 1;
      rx_random = 1;
      send_cmd(CMD_RELEASE, 10'd5);
      send_cmd(CMD_ADDREF, 10'h3FF);
      send_cmd(CMD_UNUSED, 10'h3FF);
      send_cmd(CMD_ALLOC, 10'h3FF);
      send_cmd(CMD_ALLOC, 10'd0);
      send_cmd(CMD_ADDREF, 10'd0);
      send_cmd(CMD_ADDREF, 10'd0);
      send_cmd(CMD_RELEASE, 10'd0);
      send_cmd(CMD_RELEASE, 10'd1);
      send_cmd(CMD_RELEASE, 10'd1);
      send_cmd(CMD_ADDREF, 10'd1);
      send_cmd(CMD_ALLOC, 10'd0);
      send_cmd(CMD_ALLOC, 10'd0);
      send_cmd(CMD_RELEASE, 10'd2);
      send_cmd(CMD_RELEASE, 10'd1);
      send_cmd(CMD_ALLOC, 10'd0);
      send_cmd(CMD_ALLOC, 10'd0);
      send_cmd(CMD_ADDREF, 10'd2);
      send_cmd(CMD_RELEASE, 10'd3);
      send_cmd(CMD_UNUSED, 10'd0);
      drain();
   endtask

   // Receiver holds off while the sender keeps offering, so the block stalls its input.
   task automatic test_backpressure();
      gaps_on   = 0;
      rx_random = 1;
      hold_len  = 300;
      repeat (24) send_random_cmd();
      drain();
   endtask

   task automatic test_random();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            rx_random = ($urandom_range(0, 3) != 0);
         end
         if (n == RANDOM_ITEMS / 2) drain();
         send_random_cmd();
      end
      drain();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      cycles     = 0;
      errors     = 0;
      issued_cnt = 0;
      stack_depth = 0;
      hold_len   = 0;
      gaps_on    = 0;
      rx_random  = 0;
      for (int i = 0; i < MAX_IDS; i++) begin
         id_refs[i]  = '0;
         free_ids[i] = '0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_backpressure();
      test_random();
      repeat (10) @(posedge clock);

      $display("%0d commands: %0d freed, %0d out of ids, %0d bad ids, %0d saturated",
               n_cmds, n_freed, n_nofree, n_badid, n_sat);
      $display("exercised LIFO id reuse, bad and unused commands, mixed random traffic");
      $display("and a long output hold that stalls the input");
      if (errors == 0) begin
         $display("refcounted_id_allocator_top: match");
      end else begin
         $display("refcounted_id_allocator_top: mismatch");
      end
      $finish;
   end

endmodule
`default_nettype wire
